>>> sv/ucps_pkg.sv
// Shared types and constants for the uniform-cost path search block.
// Depends on nothing; every other file but ucps_ram imports it.
package ucps_pkg;

	localparam int NODES_DEF      = 32;
	localparam int FRONTIER_DEF   = 256;
	localparam int RECORD_DEF     = 256;
	localparam int WEIGHT_DEF     = 16;

	localparam int COST_W         = 24;
	localparam logic [COST_W-1:0] COST_MAX = 24'hFFFFFF;
	localparam int PORT_NODE_W    = 5;
	localparam int PORT_WEIGHT_W  = 16;
	localparam int PATH_DEPTH     = 32;
	localparam int PATH_IDX_W     = 5;
	localparam int PATH_LEN_W     = 6;

	typedef enum logic [1:0] {
		ST_FOUND     = 2'd0,
		ST_UNREACH   = 2'd1,
		ST_FRONT_OVF = 2'd2,
		ST_REC_OVF   = 2'd3
	} status_t;

	typedef struct packed {
		logic    in_rdy;
		logic    clear_step;
		logic    init;
		logic    check;
		logic    exp_run;
		logic    exp_close;
		logic    scan_run;
		logic    take;
		logic    tr_read;
		logic    tr_push;
		logic    emit_path;
		logic    emit_fail;
		status_t fail_code;
	} ucps_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic in_valid;
		logic req_search;
		logic nodes_ok;
		logic ins_fail;
		logic exp_done;
		logic fr_empty;
		logic rec_full;
		logic scan_done;
		logic at_goal;
		logic len_full;
		logic tr_root;
		logic emit_last;
		logic out_free;
	} ucps_stat_t;

endpackage

>>> sv/ucps_if.sv
// Request and result channel interfaces of the path search block.
// Depends on ucps_pkg for field widths.
interface ucps_req_if import ucps_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic                     req_type;
	logic [PORT_NODE_W-1:0]   edge_from;
	logic [PORT_NODE_W-1:0]   edge_to;
	logic [PORT_WEIGHT_W-1:0] edge_weight;
	logic [PORT_NODE_W-1:0]   start_node;
	logic [PORT_NODE_W-1:0]   goal_node;

	modport source (output valid, req_type, edge_from, edge_to, edge_weight, start_node,
		goal_node, input ready);
	modport sink (input valid, req_type, edge_from, edge_to, edge_weight, start_node,
		goal_node, output ready);
endinterface

interface ucps_res_if import ucps_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic [PORT_NODE_W-1:0] path_node;
	logic [COST_W-1:0]      path_cost;
	logic [1:0]             status;
	logic                   last_of_run;

	modport source (output valid, path_node, path_cost, status, last_of_run, input ready);
	modport sink (input valid, path_node, path_cost, status, last_of_run, output ready);
endinterface

>>> sv/ucps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ucps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wa,
	input  logic [WIDTH-1:0] wd,
	input  logic             re,
	input  logic [AW-1:0]    ra,
	output logic [WIDTH-1:0] rd
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		if (re)
			rd <= mem[ra];
	end
endmodule

>>> sv/ucps_ctrl.sv
// Sequencer of the path search: clearing pass, expansion, frontier scan,
// path trace and result emission. Depends on ucps_pkg.
module ucps_ctrl import ucps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  ucps_stat_t stat,
	output ucps_cmd_t  cmd
);
	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_CHECK, S_EXP, S_EXP_END, S_SCAN, S_TAKE,
		S_TR_RD, S_TR_WB, S_EMIT, S_FAIL
	} state_t;

	state_t  state_q;
	status_t fail_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			fail_q  <= ST_FOUND;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (stat.clear_done)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (stat.in_valid && stat.req_search) begin
						if (stat.nodes_ok) begin
							state_q <= S_CHECK;
						end else begin
							fail_q  <= ST_UNREACH;
							state_q <= S_FAIL;
						end
					end
				end
				S_CHECK: begin
					state_q <= stat.at_goal ? S_TR_RD : S_EXP;
				end
				S_EXP: begin
					if (stat.ins_fail) begin
						fail_q  <= ST_FRONT_OVF;
						state_q <= S_FAIL;
					end else if (stat.exp_done) begin
						state_q <= S_EXP_END;
					end
				end
				S_EXP_END: begin
					priority if (stat.fr_empty) begin
						fail_q  <= ST_UNREACH;
						state_q <= S_FAIL;
					end else if (stat.rec_full) begin
						fail_q  <= ST_REC_OVF;
						state_q <= S_FAIL;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (stat.scan_done)
						state_q <= S_TAKE;
				end
				S_TAKE: begin
					state_q <= S_CHECK;
				end
				S_TR_RD: begin
					if (stat.len_full) begin
						fail_q  <= ST_REC_OVF;
						state_q <= S_FAIL;
					end else begin
						state_q <= S_TR_WB;
					end
				end
				S_TR_WB: begin
					state_q <= stat.tr_root ? S_EMIT : S_TR_RD;
				end
				S_EMIT: begin
					if (stat.out_free && stat.emit_last)
						state_q <= S_IDLE;
				end
				S_FAIL: begin
					if (stat.out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.fail_code  = fail_q;
		cmd.in_rdy     = (state_q == S_IDLE);
		cmd.clear_step = (state_q == S_CLEAR) && !stat.clear_done;
		cmd.init       = (state_q == S_IDLE) && stat.in_valid && stat.req_search &&
			stat.nodes_ok;
		cmd.check      = (state_q == S_CHECK);
		cmd.exp_run    = (state_q == S_EXP);
		cmd.exp_close  = (state_q == S_EXP_END);
		cmd.scan_run   = (state_q == S_SCAN);
		cmd.take       = (state_q == S_TAKE);
		cmd.tr_read    = (state_q == S_TR_RD) && !stat.len_full;
		cmd.tr_push    = (state_q == S_TR_WB);
		cmd.emit_path  = (state_q == S_EMIT) && stat.out_free;
		cmd.emit_fail  = (state_q == S_FAIL) && stat.out_free;
	end
endmodule

>>> sv/ucps_dp.sv
// Datapath of the path search: adjacency, frontier and record memories,
// closed set, path stack and the result register. Depends on ucps_pkg,
// ucps_if and ucps_ram.
module ucps_dp import ucps_pkg::*; #(
	parameter int NODES          = NODES_DEF,
	parameter int FRONTIER_DEPTH = FRONTIER_DEF,
	parameter int RECORD_DEPTH   = RECORD_DEF,
	parameter int WEIGHT_BITS    = WEIGHT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ucps_req_if.sink   req,
	ucps_res_if.source res,
	input  ucps_cmd_t  cmd,
	output ucps_stat_t stat
);
	localparam int NB    = $clog2(NODES);
	localparam int EDEPTH = NODES * NODES;
	localparam int EA_W  = $clog2(EDEPTH);
	localparam int EC_W  = $clog2(EDEPTH + 1);
	localparam int NC_W  = $clog2(NODES + 1);
	localparam int FA_W  = $clog2(FRONTIER_DEPTH);
	localparam int FC_W  = $clog2(FRONTIER_DEPTH + 1);
	localparam int RA_W  = $clog2(RECORD_DEPTH);
	localparam int RC_W  = $clog2(RECORD_DEPTH + 1);
	localparam int SEQ_W = $clog2(RECORD_DEPTH * NODES + 1);
	localparam int SUM_W = ((WEIGHT_BITS > COST_W) ? WEIGHT_BITS : COST_W) + 1;

	typedef struct packed {
		logic [SEQ_W-1:0]  seq;
		logic [RA_W-1:0]   parent;
		logic [COST_W-1:0] cost;
		logic [NB-1:0]     node;
	} fent_t;

	typedef struct packed {
		logic              root;
		logic [RA_W-1:0]   parent;
		logic [COST_W-1:0] cost;
		logic [NB-1:0]     node;
	} rec_t;

	typedef struct packed {
		logic [COST_W-1:0] cost;
		logic [NB-1:0]     node;
	} hop_t;

	// control state
	logic [EC_W-1:0]       clr_q;
	logic [FC_W-1:0]       fcount_q;
	logic [RC_W-1:0]       rcount_q;
	logic [SEQ_W-1:0]      seq_q;
	logic [NODES-1:0]      closed_q;
	logic [NC_W-1:0]       nb_q;
	logic                  rd_v_s1;
	logic [FC_W-1:0]       sc_q;
	logic                  sc_v_s1;
	logic [PATH_LEN_W-1:0] len_q;
	logic                  out_v_q;

	// payload state
	logic [NB-1:0]          start_q, goal_q, cn_q, nb_s1;
	logic [PORT_NODE_W-1:0] start_raw_q;
	logic [COST_W-1:0]      cc_q;
	logic [RA_W-1:0]        cur_q, tr_idx_q;
	logic [FA_W-1:0]        sc_addr_s1, best_addr_q;
	fent_t                  best_q, last_q;
	hop_t                   stack_q [PATH_DEPTH];
	logic [PORT_NODE_W-1:0] out_node_q;
	logic [COST_W-1:0]      out_cost_q;
	status_t                out_status_q;
	logic                   out_last_q;

	logic                   accept, edge_wr, from_ok, to_ok, start_ok, goal_ok;
	logic [NB-1:0]          start_in;
	logic                   ew_we, ew_re;
	logic [EA_W-1:0]        ew_wa, ew_ra;
	logic [WEIGHT_BITS-1:0] ew_wd, ew_rd;
	logic                   fr_we, fr_re;
	logic [FA_W-1:0]        fr_wa;
	fent_t                  fr_wd, fr_rd;
	logic                   rc_we;
	logic [RA_W-1:0]        rc_wa;
	rec_t                   rc_wd, rc_rd;
	logic                   exp_issue, elig, fr_full, ins, sc_issue, better;
	logic [SUM_W-1:0]       sum;
	logic [COST_W-1:0]      sat_cost;
	logic [PATH_IDX_W-1:0]  top_idx;
	hop_t                   top_hop;

	assign accept   = req.valid && req.ready;
	assign req.ready = cmd.in_rdy;
	assign from_ok  = 32'(req.edge_from) < NODES;
	assign to_ok    = 32'(req.edge_to) < NODES;
	assign start_ok = 32'(req.start_node) < NODES;
	assign goal_ok  = 32'(req.goal_node) < NODES;
	assign edge_wr  = accept && !req.req_type && from_ok && to_ok;
	assign start_in = NB'(req.start_node);

	// adjacency store, cleared after reset
	assign ew_we = cmd.clear_step || edge_wr;
	assign ew_wa = cmd.clear_step ? clr_q[EA_W-1:0] :
		EA_W'(32'(req.edge_from) * NODES + 32'(req.edge_to));
	assign ew_wd = cmd.clear_step ? '0 : WEIGHT_BITS'(32'(req.edge_weight));
	assign exp_issue = cmd.exp_run && (nb_q < NC_W'(NODES));
	assign ew_re = exp_issue;
	assign ew_ra = EA_W'(32'(cn_q) * NODES + 32'(nb_q));

	ucps_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(EDEPTH)) u_edge_ram (
		.clk(clk), .we(ew_we), .wa(ew_wa), .wd(ew_wd),
		.re(ew_re), .ra(ew_ra), .rd(ew_rd)
	);

	// neighbour insert
	assign sum      = SUM_W'(cc_q) + SUM_W'(ew_rd);
	assign sat_cost = (sum > SUM_W'(COST_MAX)) ? COST_MAX : sum[COST_W-1:0];
	assign fr_full  = (fcount_q == FC_W'(FRONTIER_DEPTH));
	assign elig     = cmd.exp_run && rd_v_s1 && (ew_rd != '0) && (nb_s1 != start_q) &&
		!closed_q[nb_s1];
	assign ins      = elig && !fr_full;

	// take moves the last frontier entry into the popped slot
	assign fr_we = ins || cmd.take;
	assign fr_wa = cmd.take ? best_addr_q : fcount_q[FA_W-1:0];
	always_comb begin
		if (cmd.take) begin
			fr_wd = last_q;
		end else begin
			fr_wd.seq    = seq_q;
			fr_wd.parent = cur_q;
			fr_wd.cost   = sat_cost;
			fr_wd.node   = nb_s1;
		end
	end
	assign sc_issue = cmd.scan_run && (sc_q < fcount_q);
	assign fr_re    = sc_issue;

	ucps_ram #(.WIDTH($bits(fent_t)), .DEPTH(FRONTIER_DEPTH)) u_front_ram (
		.clk(clk), .we(fr_we), .wa(fr_wa), .wd(fr_wd),
		.re(fr_re), .ra(sc_q[FA_W-1:0]), .rd(fr_rd)
	);

	// lowest cost wins; on a tie the later insert wins
	assign better = (sc_addr_s1 == '0) || (fr_rd.cost < best_q.cost) ||
		((fr_rd.cost == best_q.cost) && (fr_rd.seq > best_q.seq));

	assign rc_we = cmd.init || cmd.take;
	assign rc_wa = cmd.take ? rcount_q[RA_W-1:0] : '0;
	always_comb begin
		if (cmd.take) begin
			rc_wd.root   = 1'b0;
			rc_wd.parent = best_q.parent;
			rc_wd.cost   = best_q.cost;
			rc_wd.node   = best_q.node;
		end else begin
			rc_wd.root   = 1'b1;
			rc_wd.parent = '0;
			rc_wd.cost   = '0;
			rc_wd.node   = start_in;
		end
	end

	ucps_ram #(.WIDTH($bits(rec_t)), .DEPTH(RECORD_DEPTH)) u_rec_ram (
		.clk(clk), .we(rc_we), .wa(rc_wa), .wd(rc_wd),
		.re(cmd.tr_read), .ra(tr_idx_q), .rd(rc_rd)
	);

	assign top_idx = PATH_IDX_W'(len_q - PATH_LEN_W'(1));
	assign top_hop = stack_q[top_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			fcount_q <= '0;
			rcount_q <= '0;
			seq_q    <= '0;
			closed_q <= '0;
			nb_q     <= '0;
			rd_v_s1  <= 1'b0;
			sc_q     <= '0;
			sc_v_s1  <= 1'b0;
			len_q    <= '0;
			out_v_q  <= 1'b0;
		end else begin
			rd_v_s1 <= exp_issue;
			sc_v_s1 <= sc_issue;
			if (cmd.clear_step)
				clr_q <= clr_q + EC_W'(1);
			if (cmd.init) begin
				fcount_q <= '0;
				rcount_q <= RC_W'(1);
				seq_q    <= '0;
				closed_q <= '0;
			end
			if (cmd.check) begin
				nb_q  <= '0;
				len_q <= '0;
			end else if (exp_issue) begin
				nb_q <= nb_q + NC_W'(1);
			end
			if (ins) begin
				fcount_q <= fcount_q + FC_W'(1);
				seq_q    <= seq_q + SEQ_W'(1);
			end
			if (cmd.exp_close) begin
				closed_q[cn_q] <= 1'b1;
				sc_q           <= '0;
			end else if (sc_issue) begin
				sc_q <= sc_q + FC_W'(1);
			end
			if (cmd.take) begin
				fcount_q <= fcount_q - FC_W'(1);
				rcount_q <= rcount_q + RC_W'(1);
			end
			if (cmd.tr_push)
				len_q <= len_q + PATH_LEN_W'(1);
			else if (cmd.emit_path)
				len_q <= len_q - PATH_LEN_W'(1);
			if (cmd.emit_path || cmd.emit_fail)
				out_v_q <= 1'b1;
			else if (res.ready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		nb_s1      <= NB'(nb_q);
		sc_addr_s1 <= sc_q[FA_W-1:0];
		if (accept && req.req_type) begin
			start_raw_q <= req.start_node;
			start_q     <= start_in;
			goal_q      <= NB'(req.goal_node);
		end
		if (cmd.init) begin
			cn_q  <= start_in;
			cc_q  <= '0;
			cur_q <= '0;
		end
		if (sc_v_s1) begin
			last_q <= fr_rd;
			if (better) begin
				best_q      <= fr_rd;
				best_addr_q <= sc_addr_s1;
			end
		end
		if (cmd.take) begin
			cur_q <= rcount_q[RA_W-1:0];
			cn_q  <= best_q.node;
			cc_q  <= best_q.cost;
		end
		if (cmd.check)
			tr_idx_q <= cur_q;
		if (cmd.tr_push) begin
			stack_q[len_q[PATH_IDX_W-1:0]] <= '{cost: rc_rd.cost, node: rc_rd.node};
			tr_idx_q <= rc_rd.parent;
		end
		if (cmd.emit_path) begin
			out_node_q   <= PORT_NODE_W'(top_hop.node);
			out_cost_q   <= top_hop.cost;
			out_status_q <= ST_FOUND;
			out_last_q   <= (len_q == PATH_LEN_W'(1));
		end else if (cmd.emit_fail) begin
			out_node_q   <= start_raw_q;
			out_cost_q   <= '0;
			out_status_q <= cmd.fail_code;
			out_last_q   <= 1'b1;
		end
	end

	assign res.valid       = out_v_q;
	assign res.path_node   = out_node_q;
	assign res.path_cost   = out_cost_q;
	assign res.status      = out_status_q;
	assign res.last_of_run = out_last_q;

	always_comb begin
		stat            = '0;
		stat.clear_done = (clr_q == EC_W'(EDEPTH));
		stat.in_valid   = req.valid;
		stat.req_search = req.req_type;
		stat.nodes_ok   = start_ok && goal_ok;
		stat.ins_fail   = elig && fr_full;
		stat.exp_done   = (nb_q == NC_W'(NODES)) && !rd_v_s1;
		stat.fr_empty   = (fcount_q == '0);
		stat.rec_full   = (rcount_q == RC_W'(RECORD_DEPTH));
		stat.scan_done  = (sc_q == fcount_q) && !sc_v_s1;
		stat.at_goal    = (cn_q == goal_q);
		stat.len_full   = (len_q == PATH_LEN_W'(PATH_DEPTH));
		stat.tr_root    = rc_rd.root;
		stat.emit_last  = (len_q == PATH_LEN_W'(1));
		stat.out_free   = !out_v_q || res.ready;
	end
endmodule

>>> sv/uniform_cost_path_search.sv
// Uniform-cost path search over a directed graph of NODES nodes. After reset the
// block sweeps the adjacency memory to zero, one entry per cycle, and takes no
// request until that is done. Edge writes can follow back to back. A search holds
// ready low until its last result is loaded: it takes the request and checks the goal,
// then for each expansion walks the neighbours through the adjacency port, scans the
// frontier for the minimum through the frontier port, pops it and checks the goal again,
// then traces the parents to build the path and emits one result per path node.
// The result register lets the next request in while the final result waits.
module uniform_cost_path_search import ucps_pkg::*; #(
	parameter int NODES          = NODES_DEF,
	parameter int FRONTIER_DEPTH = FRONTIER_DEF,
	parameter int RECORD_DEPTH   = RECORD_DEF,
	parameter int WEIGHT_BITS    = WEIGHT_DEF
) (
	input logic        clk,
	input logic        arst_n,
	ucps_req_if.sink   req,
	ucps_res_if.source res
);
	ucps_cmd_t  cmd;
	ucps_stat_t stat;

	ucps_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .stat(stat), .cmd(cmd)
	);

	ucps_dp #(
		.NODES(NODES), .FRONTIER_DEPTH(FRONTIER_DEPTH),
		.RECORD_DEPTH(RECORD_DEPTH), .WEIGHT_BITS(WEIGHT_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .res(res), .cmd(cmd), .stat(stat)
	);

	a_path_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_path |-> stat.out_free)
		else $error("path result loaded over a waiting result");

	a_fail_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_fail |-> stat.out_free)
		else $error("status result loaded over a waiting result");

	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> stat.clear_done)
		else $error("request taken before the adjacency sweep finished");

	a_take_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> !stat.rec_full && !stat.fr_empty)
		else $error("pop with no record room or an empty frontier");
endmodule

>>> tb/tb_top.sv
// Self-checking bench for uniform_cost_path_search: directed table, then random requests.
// Depends on ucps_pkg and the request/result interfaces in ucps_if.sv.
module tb_top;
	import ucps_pkg::*;

	localparam int N_NODES   = 32;
	localparam int FR_DEPTH  = 256;
	localparam int REC_DEPTH = 256;
	localparam int RAND_REQS = 300;
	localparam int QUIET_AT  = 250;

	typedef struct packed {
		logic [PORT_NODE_W-1:0] node;
		logic [COST_W-1:0]      cost;
		status_t                status;
		logic                   last;
	} path_item_t;

	typedef struct {
		logic [PORT_NODE_W-1:0] node;
		int unsigned            cost;
		int                     parent;
	} visit_t;

	typedef struct {
		logic                     is_search;
		logic [PORT_NODE_W-1:0]   from_n;
		logic [PORT_NODE_W-1:0]   to_n;
		logic [PORT_WEIGHT_W-1:0] weight;
		logic [PORT_NODE_W-1:0]   start_n;
		logic [PORT_NODE_W-1:0]   goal_n;
		logic                     typed;
		path_item_t               exp;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ucps_req_if req_ch();
	ucps_res_if res_ch();

	uniform_cost_path_search dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	logic [PORT_WEIGHT_W-1:0] adj_weight [N_NODES][N_NODES];
	path_item_t path_expect [$];
	stim_row_t  dir_rows [$];
	int  errors = 0;
	int  reqs_sent = 0;
	bit  quiet = 1'b0;
	bit  pressure_done = 1'b0;

	function automatic void push_fail(logic [PORT_NODE_W-1:0] s, status_t code);
		path_item_t p;
		p.node   = s;
		p.cost   = '0;
		p.status = code;
		p.last   = 1'b1;
		path_expect.push_back(p);
	endfunction

	// Cheapest-first search over the shadow adjacency; appends the expected results.
	function automatic void predict_search(logic [PORT_NODE_W-1:0] s, logic [PORT_NODE_W-1:0] g);
		visit_t      open_q [$];
		visit_t      done_q [$];
		visit_t      v;
		logic [31:0] closed;
		int          cur, pos, idx, len;
		int unsigned sum;
		int          trail [PATH_DEPTH];
		path_item_t  p;
		closed = '0;
		v.node = s;
		v.cost = 0;
		v.parent = -1;
		done_q.push_back(v);
		cur = 0;
		while (done_q[cur].node != g) begin
			for (int i = 0; i < N_NODES; i++) begin
				if (adj_weight[done_q[cur].node][i] == 0 || i == s || closed[i])
					continue;
				sum = done_q[cur].cost + adj_weight[done_q[cur].node][i];
				if (sum > 32'(COST_MAX))
					sum = 32'(COST_MAX);
				if (open_q.size() >= FR_DEPTH) begin
					push_fail(s, ST_FRONT_OVF);
					return;
				end
				pos = 0;
				while (pos < open_q.size() && sum > open_q[pos].cost)
					pos++;
				v.node = PORT_NODE_W'(i);
				v.cost = sum;
				v.parent = cur;
				open_q.insert(pos, v);
			end
			closed[done_q[cur].node] = 1'b1;
			if (open_q.size() == 0) begin
				push_fail(s, ST_UNREACH);
				return;
			end
			if (done_q.size() >= REC_DEPTH) begin
				push_fail(s, ST_REC_OVF);
				return;
			end
			done_q.push_back(open_q.pop_front());
			cur = done_q.size() - 1;
		end
		len = 0;
		idx = cur;
		while (idx != -1) begin
			if (len >= PATH_DEPTH) begin
				push_fail(s, ST_REC_OVF);
				return;
			end
			trail[len] = idx;
			len++;
			idx = done_q[idx].parent;
		end
		for (int i = 0; i < len; i++) begin
			p.node   = done_q[trail[len-1-i]].node;
			p.cost   = COST_W'(done_q[trail[len-1-i]].cost);
			p.status = ST_FOUND;
			p.last   = (i + 1 == len);
			path_expect.push_back(p);
		end
	endfunction

	function automatic void add_write(int f, int t, int w);
		stim_row_t r;
		r = '{default: '0};
		r.from_n = PORT_NODE_W'(f);
		r.to_n = PORT_NODE_W'(t);
		r.weight = PORT_WEIGHT_W'(w);
		dir_rows.push_back(r);
	endfunction

	function automatic void add_search(int s, int g, bit typed, status_t code);
		stim_row_t r;
		r = '{default: '0};
		r.is_search = 1'b1;
		r.start_n = PORT_NODE_W'(s);
		r.goal_n = PORT_NODE_W'(g);
		r.typed = typed;
		r.exp.node = PORT_NODE_W'(s);
		r.exp.cost = '0;
		r.exp.status = code;
		r.exp.last = 1'b1;
		dir_rows.push_back(r);
	endfunction

	// Drive one request and hold it until the block takes it.
	task automatic send_request(stim_row_t r);
		req_ch.valid       <= 1'b1;
		req_ch.req_type    <= r.is_search;
		req_ch.edge_from   <= r.from_n;
		req_ch.edge_to     <= r.to_n;
		req_ch.edge_weight <= r.weight;
		req_ch.start_node  <= r.start_n;
		req_ch.goal_node   <= r.goal_n;
		do @(posedge clk); while (!req_ch.ready);
		if (!r.is_search)
			adj_weight[r.from_n][r.to_n] = r.weight;
		else if (r.typed)
			path_expect.push_back(r.exp);
		else
			predict_search(r.start_n, r.goal_n);
		reqs_sent++;
	endtask

	task automatic sender_gap();
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	function automatic stim_row_t random_row(int base);
		stim_row_t r;
		int pick;
		r = '{default: '0};
		r.from_n  = PORT_NODE_W'($urandom);
		r.to_n    = PORT_NODE_W'($urandom);
		r.weight  = PORT_WEIGHT_W'($urandom);
		r.start_n = PORT_NODE_W'($urandom);
		r.goal_n  = PORT_NODE_W'($urandom);
		if ($urandom_range(0, 9) < 7) begin
			if ($urandom_range(0, 9) != 0) begin
				r.from_n = PORT_NODE_W'(base + int'($urandom_range(0, 7)));
				r.to_n   = PORT_NODE_W'(base + int'($urandom_range(0, 7)));
			end
			pick = int'($urandom_range(0, 9));
			if (pick < 2)
				r.weight = '0;
			else if (pick == 2)
				r.weight = '1;
			else if (pick < 9)
				r.weight = PORT_WEIGHT_W'($urandom_range(1, 300));
		end else begin
			r.is_search = 1'b1;
			if ($urandom_range(0, 7) != 0) begin
				r.start_n = PORT_NODE_W'(base + int'($urandom_range(0, 7)));
				r.goal_n  = PORT_NODE_W'(base + int'($urandom_range(0, 7)));
			end
		end
		return r;
	endfunction

	initial begin
		int base;
		for (int i = 0; i < N_NODES; i++)
			for (int j = 0; j < N_NODES; j++)
				adj_weight[i][j] = '0;
		req_ch.valid       <= 1'b0;
		req_ch.req_type    <= 1'b0;
		req_ch.edge_from   <= '0;
		req_ch.edge_to     <= '0;
		req_ch.edge_weight <= '0;
		req_ch.start_node  <= '0;
		req_ch.goal_node   <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// empty graph, start equal to goal at both ends of the node range
		add_search(0, 5, 1'b1, ST_UNREACH);
		add_search(7, 7, 1'b1, ST_FOUND);
		add_search(31, 31, 1'b1, ST_FOUND);
		add_search(0, 0, 1'b1, ST_FOUND);
		add_write(0, 1, 65535);
		add_write(1, 2, 65535);
		add_search(0, 2, 1'b0, ST_FOUND);
		add_write(2, 31, 1);
		add_write(1, 0, 5);
		add_search(0, 31, 1'b0, ST_FOUND);
		add_write(0, 3, 1);
		add_write(3, 2, 1);
		add_search(0, 2, 1'b0, ST_FOUND);
		add_write(1, 2, 0);
		add_write(3, 2, 0);
		// node 2 is unreachable from node 0 once the edges into it are gone
		add_search(0, 2, 1'b1, ST_UNREACH);
		add_write(31, 31, 65535);
		add_write(31, 0, 2);
		add_search(31, 1, 1'b0, ST_FOUND);
		add_search(2, 1, 1'b0, ST_FOUND);
		foreach (dir_rows[k]) begin
			send_request(dir_rows[k]);
			sender_gap();
		end

		base = 0;
		for (int n = 0; n < RAND_REQS; n++) begin
			if (n % 40 == 0)
				base = int'($urandom_range(0, 24));
			if (n >= QUIET_AT)
				quiet = 1'b1;
			send_request(random_row(base));
			sender_gap();
		end
		req_ch.valid <= 1'b0;

		while (path_expect.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off that backs up the request side.
	initial begin
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!pressure_done && reqs_sent >= 100) begin
				res_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
				pressure_done = 1'b1;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		path_item_t e;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (path_expect.size() == 0) begin
				$error("unexpected result node=%0d cost=%0d status=%0d",
					res_ch.path_node, res_ch.path_cost, res_ch.status);
				errors++;
			end else begin
				e = path_expect.pop_front();
				if (res_ch.path_node !== e.node) begin
					$error("path_node expected %0d actual %0d", e.node, res_ch.path_node);
					errors++;
				end
				if (res_ch.path_cost !== e.cost) begin
					$error("path_cost expected %0d actual %0d", e.cost, res_ch.path_cost);
					errors++;
				end
				if (res_ch.status !== e.status) begin
					$error("status expected %0d actual %0d", e.status, res_ch.status);
					errors++;
				end
				if (res_ch.last_of_run !== e.last) begin
					$error("last_of_run expected %0d actual %0d", e.last, res_ch.last_of_run);
					errors++;
				end
			end
		end
	end

	initial begin
		#(12 * 80000000);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
